@@ hdl/pcfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pcfa_pkg
// Shared constants and types of the per-core page free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcfa_pkg;

    localparam int NUM_CORES  = 8;
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W = 32;
    localparam int CORE_W = 3;
    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int LINK_W = IDX_W + 1;
    localparam int PN_W   = ADDR_W - PAGE_SHIFT;
    localparam int BASE_W = ADDR_W + 1 - PAGE_SHIFT;
    localparam int CSEL_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CFG_W  = 1;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OOM = 2'd1;
    localparam logic [1:0] STATUS_BAD = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_W-1:0] CFG_LOWER = 1'b0;
    localparam logic [CFG_W-1:0] CFG_UPPER = 1'b1;

    localparam logic [ADDR_W-1:0] LOWER_RESET = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] UPPER_RESET = 32'h8800_0000;

    typedef struct packed {
        logic load;
        logic exec;
    } pcfa_cmd_t;

    function automatic logic [BASE_W-1:0] base_page(input logic [ADDR_W-1:0] lower);
        logic [ADDR_W:0] sum;
        sum = {1'b0, lower} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
        return sum[ADDR_W:PAGE_SHIFT];
    endfunction

endpackage

`default_nettype wire

@@ hdl/pcfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcfa_ctrl
// Request sequencer: takes an item, runs the execute cycle, strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pcfa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output pcfa_pkg::pcfa_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == ST_EXEC);
    assign done     = done_reg;
    assign cmd.load = (state_reg == ST_IDLE) && start;
    assign cmd.exec = (state_reg == ST_EXEC);

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted item not executed");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execute cycle lasted more than one cycle");

    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done)
        else $error("result strobe missing after execute");

    a_done_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.exec) && !busy)
        else $error("result strobe without execute");

endmodule

`default_nettype wire

@@ hdl/pcfa_dp.sv @@
// ----------------------------------------------------------------------------
// pcfa_dp
// Datapath: bound registers, list heads, next-page memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pcfa_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pcfa_pkg::pcfa_cmd_t                 cmd,
    input  wire logic                                req_type,
    input  wire logic [pcfa_pkg::CORE_W-1:0]         core_id,
    input  wire logic [pcfa_pkg::ADDR_W-1:0]         page_addr,
    input  wire logic                                cfg_we,
    input  wire logic [pcfa_pkg::CFG_W-1:0]          cfg_index,
    input  wire logic [pcfa_pkg::ADDR_W-1:0]         cfg_data,
    output logic [1:0]                               status,
    output logic [pcfa_pkg::ADDR_W-1:0]              alloc_addr
);

    logic [pcfa_pkg::ADDR_W-1:0] lower_reg;
    logic [pcfa_pkg::ADDR_W-1:0] upper_reg;
    logic [pcfa_pkg::BASE_W-1:0] base_reg;

    logic [pcfa_pkg::IDX_W-1:0]  head_page_reg [pcfa_pkg::NUM_CORES];
    logic [pcfa_pkg::NUM_CORES-1:0] head_valid_reg;

    logic [pcfa_pkg::LINK_W-1:0] link_mem [pcfa_pkg::MAX_PAGES];
    logic [pcfa_pkg::LINK_W-1:0] rd_data_reg;

    logic                        type_reg;
    logic [pcfa_pkg::CSEL_W-1:0] core_reg;
    logic [pcfa_pkg::CSEL_W-1:0] sel_reg;
    logic                        found_reg;
    logic [pcfa_pkg::IDX_W-1:0]  pop_idx_reg;
    logic                        free_ok_reg;
    logic [pcfa_pkg::BASE_W-1:0] free_idx_reg;

    logic [1:0]                  status_reg;
    logic [pcfa_pkg::ADDR_W-1:0] alloc_addr_reg;

    logic                        own_ok;
    logic [pcfa_pkg::CSEL_W-1:0] first_core;
    logic [pcfa_pkg::CSEL_W-1:0] sel_core;
    logic                        core_ok;
    logic                        free_ok;
    logic [pcfa_pkg::BASE_W-1:0] free_idx;
    logic                        idx_ok;
    logic [pcfa_pkg::PN_W-1:0]   page_num;
    logic [pcfa_pkg::LINK_W-1:0] push_link;

    // Own list first, otherwise the lowest non-empty list.
    always_comb
    begin
        core_ok    = int'(core_id) < pcfa_pkg::NUM_CORES;
        own_ok     = core_ok && head_valid_reg[core_id[pcfa_pkg::CSEL_W-1:0]];
        first_core = '0;
        for (int c = pcfa_pkg::NUM_CORES - 1; c >= 0; c--)
        begin
            if (head_valid_reg[c])
            begin
                first_core = pcfa_pkg::CSEL_W'(c);
            end
        end
        sel_core = own_ok ? core_id[pcfa_pkg::CSEL_W-1:0] : first_core;
    end

    always_comb
    begin
        free_ok  = core_ok
                   && (page_addr[pcfa_pkg::PAGE_SHIFT-1:0] == '0)
                   && (page_addr >= lower_reg)
                   && (page_addr < upper_reg);
        free_idx = {1'b0, page_addr[pcfa_pkg::ADDR_W-1:pcfa_pkg::PAGE_SHIFT]} - base_reg;
        idx_ok   = free_ok_reg && (free_idx_reg < pcfa_pkg::BASE_W'(pcfa_pkg::MAX_PAGES));
        page_num = base_reg[pcfa_pkg::PN_W-1:0] + pcfa_pkg::PN_W'(pop_idx_reg);
        push_link = {head_valid_reg[core_reg], head_page_reg[core_reg]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= pcfa_pkg::LOWER_RESET;
            upper_reg <= pcfa_pkg::UPPER_RESET;
            base_reg  <= pcfa_pkg::base_page(pcfa_pkg::LOWER_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcfa_pkg::CFG_LOWER:
                begin
                    lower_reg <= cfg_data;
                    base_reg  <= pcfa_pkg::base_page(cfg_data);
                end
                pcfa_pkg::CFG_UPPER:
                begin
                    upper_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Latch the request and the selected list head.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg     <= req_type;
            core_reg     <= core_id[pcfa_pkg::CSEL_W-1:0];
            sel_reg      <= sel_core;
            found_reg    <= |head_valid_reg;
            pop_idx_reg  <= head_page_reg[sel_core];
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            for (int c = 0; c < pcfa_pkg::NUM_CORES; c++)
            begin
                head_page_reg[c] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (type_reg == pcfa_pkg::REQ_FREE)
            begin
                if (idx_ok)
                begin
                    head_page_reg[core_reg]  <= free_idx_reg[pcfa_pkg::IDX_W-1:0];
                    head_valid_reg[core_reg] <= 1'b1;
                end
            end
            else if (found_reg)
            begin
                head_valid_reg[sel_reg] <= rd_data_reg[pcfa_pkg::IDX_W];
                head_page_reg[sel_reg]  <= rd_data_reg[pcfa_pkg::IDX_W] ?
                                           rd_data_reg[pcfa_pkg::IDX_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && (type_reg == pcfa_pkg::REQ_FREE) && idx_ok)
        begin
            link_mem[free_idx_reg[pcfa_pkg::IDX_W-1:0]] <= push_link;
        end
        if (cmd.load)
        begin
            rd_data_reg <= link_mem[head_page_reg[sel_core]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (type_reg == pcfa_pkg::REQ_FREE)
            begin
                status_reg     <= idx_ok ? pcfa_pkg::STATUS_OK : pcfa_pkg::STATUS_BAD;
                alloc_addr_reg <= '0;
            end
            else if (found_reg)
            begin
                status_reg     <= pcfa_pkg::STATUS_OK;
                alloc_addr_reg <= {page_num, pcfa_pkg::PAGE_SHIFT'(0)};
            end
            else
            begin
                status_reg     <= pcfa_pkg::STATUS_OOM;
                alloc_addr_reg <= '0;
            end
        end
    end

    assign status     = status_reg;
    assign alloc_addr = alloc_addr_reg;

endmodule

`default_nettype wire

@@ hdl/per_core_page_free_list_allocator_core.sv @@
// ----------------------------------------------------------------------------
// per_core_page_free_list_allocator_core
// Per-core LIFO page free lists with stealing on an empty own list.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, core_id, page_addr) is taken at a clock edge with
//   start high and busy low. A free pushes the page onto core_id's list or
//   reports a bad address; an allocate pops core_id's list, else the lowest
//   non-empty list of another core, else reports out of memory.
//   busy is high for one cycle after the item is taken. done pulses for one
//   cycle with status and alloc_addr once the execute cycle has registered them.
//   No new item is taken while busy: the cycle taking the item issues the read of
//   the next-page memory, the execute cycle writes back heads and links.
//   A new item may be taken in the cycle that done is shown.
//   The result is shown once; the receiver cannot stall it.
//   The user writes lower_bound and upper_bound through cfg_we, cfg_index and
//   cfg_data only while no item is in progress; the block does not enforce this.
//   Reset empties all lists and loads the bound reset values; the next-page
//   memory is not cleared, since only pushed entries are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module per_core_page_free_list_allocator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [pcfa_pkg::CORE_W-1:0]   core_id,
    input  wire logic [pcfa_pkg::ADDR_W-1:0]   page_addr,
    input  wire logic                          cfg_we,
    input  wire logic [pcfa_pkg::CFG_W-1:0]    cfg_index,
    input  wire logic [pcfa_pkg::ADDR_W-1:0]   cfg_data,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [pcfa_pkg::ADDR_W-1:0]        alloc_addr
);

    pcfa_pkg::pcfa_cmd_t cmd;

    pcfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    pcfa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .core_id    (core_id),
        .page_addr  (page_addr),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .alloc_addr (alloc_addr)
    );

endmodule

`default_nettype wire
